// ===== rtl/cleb_pkg.sv =====
`default_nettype none

package cleb_pkg;

  typedef enum logic [2:0] {
    ACT_INSERT = 3'd0,
    ACT_LEFT   = 3'd1,
    ACT_RIGHT  = 3'd2,
    ACT_BKSP   = 3'd3,
    ACT_READ   = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_BOUNDARY = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_RANGE    = 2'd3
  } status_e;

  localparam int unsigned OUT_CNT_W = 11;
  localparam int unsigned POS_W     = 10;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned ACT_W     = 3;
  localparam int unsigned STAT_W    = 2;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;  // request taken: latch fields, start memory read
    logic commit;   // write back, update counts, load result
  } cleb_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/cleb_ram.sv =====
`default_nettype none

module cleb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cleb_ctrl.sv =====
`default_nettype none

module cleb_ctrl import cleb_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output cleb_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d         = state_q;
    out_valid_d     = out_valid_q;
    in_ready_o      = 1'b0;
    cmd_o.capture   = 1'b0;
    cmd_o.commit    = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // result slot must be free or freeing
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/cleb_dpath.sv =====
`default_nettype none

module cleb_dpath import cleb_pkg::*; #(
  parameter int unsigned CAPACITY = 1024
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cleb_cmd_t            cmd_i,
  input  wire logic [ACT_W-1:0]     action_i,
  input  wire logic [CHAR_W-1:0]    char_in_i,
  input  wire logic [POS_W-1:0]     position_i,
  output logic      [CHAR_W-1:0]    char_out_o,
  output logic      [OUT_CNT_W-1:0] text_length_o,
  output logic      [OUT_CNT_W-1:0] cursor_pos_o,
  output logic      [STAT_W-1:0]    status_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
  localparam logic [PW-1:0] CAP_PC = PW'(CAPACITY);

  logic [CW-1:0]     left_q, left_d, right_q, right_d;
  logic [ACT_W-1:0]  act_q;
  logic [CHAR_W-1:0] char_q;
  logic [POS_W-1:0]  pos_q;
  logic [CHAR_W-1:0] char_out_q, char_out_d;
  logic [STAT_W-1:0] status_q, status_d;

  logic [CW-1:0]     len;
  logic [PW-1:0]     left_x, right_x, len_x, pin_x, pq_x, far_addr;
  logic [AW-1:0]     raddr, waddr;
  logic [CHAR_W-1:0] rdata, wdata;
  logic              we;

  assign len     = left_q + right_q;
  assign left_x  = PW'(left_q);
  assign right_x = PW'(right_q);
  assign len_x   = PW'(len);
  assign pin_x   = PW'(position_i);
  assign pq_x    = PW'(pos_q);
  assign far_addr = CAP_PC - right_x + pin_x - left_x;

  // read address from the request fields, issued as the request is taken
  always_comb begin
    raddr = '0;
    unique case (action_i)
      ACT_LEFT:  raddr = AW'(left_q - CW'(1));
      ACT_RIGHT: raddr = AW'(CAP_C - right_q);
      ACT_READ: begin
        if (pin_x < left_x) begin
          raddr = AW'(pin_x);
        end else begin
          raddr = AW'(far_addr);
        end
      end
      default:   raddr = '0;
    endcase
  end

  cleb_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.capture),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q  <= action_i;
      char_q <= char_in_i;
      pos_q  <= position_i;
    end
  end

  // write back and count update
  always_comb begin
    we         = 1'b0;
    waddr      = AW'(left_q);
    wdata      = rdata;
    left_d     = left_q;
    right_d    = right_q;
    status_d   = STAT_DONE;
    char_out_d = '0;
    unique case (act_q)
      ACT_INSERT: begin
        if (len >= CAP_C) begin
          status_d = STAT_FULL;
        end else begin
          we     = 1'b1;
          wdata  = char_q;
          left_d = left_q + CW'(1);
        end
      end
      ACT_LEFT: begin
        if (left_q == '0) begin
          status_d = STAT_BOUNDARY;
        end else begin
          we      = 1'b1;
          waddr   = AW'(CAP_C - right_q - CW'(1));
          left_d  = left_q - CW'(1);
          right_d = right_q + CW'(1);
        end
      end
      ACT_RIGHT: begin
        if (right_q == '0) begin
          status_d = STAT_BOUNDARY;
        end else begin
          we      = 1'b1;
          left_d  = left_q + CW'(1);
          right_d = right_q - CW'(1);
        end
      end
      ACT_BKSP: begin
        if (left_q == '0) begin
          status_d = STAT_BOUNDARY;
        end else begin
          left_d = left_q - CW'(1);
        end
      end
      ACT_READ: begin
        if (pq_x >= len_x) begin
          status_d = STAT_RANGE;
        end else begin
          char_out_d = rdata;
        end
      end
      default: begin
        status_d = STAT_DONE;
      end
    endcase
    if (!cmd_i.commit) begin
      we      = 1'b0;
      left_d  = left_q;
      right_d = right_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      right_q <= '0;
    end else begin
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      char_out_q <= char_out_d;
      status_q   <= status_d;
    end
  end

  // counts move only at commit, so they hold with the result
  assign char_out_o    = char_out_q;
  assign status_o      = status_q;
  assign text_length_o = OUT_CNT_W'(len);
  assign cursor_pos_o  = OUT_CNT_W'(left_q);

endmodule

`default_nettype wire

// ===== rtl/cursor_line_edit_buffer.sv =====
// flow: the memory read is issued as the request is taken, then the write-back and the result
//   are registered at commit; a new request is not taken until the last one commits, and a
//   result left waiting holds the next request before its commit
// reset: cursor and length counts clear to zero, text memory is not cleared
`default_nettype none

module cursor_line_edit_buffer import cleb_pkg::*; #(
  parameter int unsigned CAPACITY = 1024
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // request channel
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [ACT_W-1:0]     action_i,
  input  wire logic [CHAR_W-1:0]    char_in_i,
  input  wire logic [POS_W-1:0]     position_i,
  // result channel
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic      [CHAR_W-1:0]    char_out_o,
  output logic      [OUT_CNT_W-1:0] text_length_o,
  output logic      [OUT_CNT_W-1:0] cursor_pos_o,
  output logic      [STAT_W-1:0]    status_o
);

  // controller sequences capture and commit, datapath owns the gap buffer
  cleb_cmd_t cmd;

  // handshake control: idle takes a request, exec commits once the result slot is free
  cleb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // gap buffer: left text at the low end, right text at the high end,
  // cursor moves carry one character across the gap
  cleb_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .action_i      (action_i),
    .char_in_i     (char_in_i),
    .position_i    (position_i),
    .char_out_o    (char_out_o),
    .text_length_o (text_length_o),
    .cursor_pos_o  (cursor_pos_o),
    .status_o      (status_o)
  );

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cleb_pkg::*;

  localparam int unsigned CAPACITY     = 1024;
  localparam int unsigned MAX_REPORTS  = 10;
  // a result is registered at commit after its request is taken, so a short tail is plenty
  localparam int unsigned DRAIN_CYCLES = 16;
  // slowest honest run is far below this, even with every stall at its worst
  localparam longint unsigned WATCHDOG_NS = 64'd10_000_000;

  // one request as it goes over the input channel
  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [CHAR_W-1:0] ch;
    logic [POS_W-1:0]  pos;
  } edit_req_t;

  // one result as it comes back on the output channel
  typedef struct packed {
    logic [CHAR_W-1:0]    ch;
    logic [OUT_CNT_W-1:0] len;
    logic [OUT_CNT_W-1:0] cur;
    logic [STAT_W-1:0]    status;
  } edit_reply_t;

  // shapes of random traffic
  typedef enum {
    MIX_SHORT,  // balanced edits on short text, hits both ends of the cursor range
    FILL_UP,    // mostly inserts, drives the buffer to full and past it
    MIX_FULL    // balanced edits while the buffer sits near capacity
  } traffic_e;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // request channel, known from time zero
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [ACT_W-1:0]  action_i   = '0;
  logic [CHAR_W-1:0] char_in_i  = '0;
  logic [POS_W-1:0]  position_i = '0;

  // result channel
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [CHAR_W-1:0]    char_out_o;
  logic [OUT_CNT_W-1:0] text_length_o;
  logic [OUT_CNT_W-1:0] cursor_pos_o;
  logic [STAT_W-1:0]    status_o;

  // stimulus waiting to go out, and results still owed by the block
  edit_req_t   pending_edits_q[$];
  edit_reply_t edit_replies_q[$];
  edit_req_t   held_edit;
  edit_reply_t want_reply;

  // our own copy of the gap buffer: left text at the bottom, right text at the top
  logic [CHAR_W-1:0] text_mirror [CAPACITY];
  int unsigned       left_cnt  = 0;
  int unsigned       right_cnt = 0;

  // length and cursor as the stimulus generator expects them, used only to shape traffic
  int unsigned gen_len = 0;
  int unsigned gen_cur = 0;

  // idle and stall rates in percent, changed between phases at the falling edge
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;

  int unsigned mismatch_cnt = 0;

  cursor_line_edit_buffer #(
    .CAPACITY (CAPACITY)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .char_in_i     (char_in_i),
    .position_i    (position_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .char_out_o    (char_out_o),
    .text_length_o (text_length_o),
    .cursor_pos_o  (cursor_pos_o),
    .status_o      (status_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // apply one accepted request to the mirror and queue the result it must produce
  function automatic void apply_edit(input edit_req_t r);
    edit_reply_t res;
    int unsigned len;
    len        = left_cnt + right_cnt;
    res.ch     = '0;
    res.status = STAT_DONE;
    case (r.act)
      ACT_INSERT: begin
        if (len >= CAPACITY) begin
          // full: character dropped
          res.status = STAT_FULL;
        end else begin
          text_mirror[left_cnt] = r.ch;
          left_cnt++;
        end
      end
      ACT_LEFT: begin
        if (left_cnt == 0) begin
          res.status = STAT_BOUNDARY;
        end else begin
          // last char of the left part crosses the gap to the top
          text_mirror[CAPACITY - right_cnt - 1] = text_mirror[left_cnt - 1];
          left_cnt--;
          right_cnt++;
        end
      end
      ACT_RIGHT: begin
        if (right_cnt == 0) begin
          res.status = STAT_BOUNDARY;
        end else begin
          // first char of the right part crosses the gap to the bottom
          text_mirror[left_cnt] = text_mirror[CAPACITY - right_cnt];
          left_cnt++;
          right_cnt--;
        end
      end
      ACT_BKSP: begin
        if (left_cnt == 0) begin
          res.status = STAT_BOUNDARY;
        end else begin
          left_cnt--;
        end
      end
      ACT_READ: begin
        if (r.pos >= len) begin
          res.status = STAT_RANGE;
        end else if (r.pos < left_cnt) begin
          res.ch = text_mirror[r.pos];
        end else begin
          res.ch = text_mirror[CAPACITY - right_cnt + (r.pos - left_cnt)];
        end
      end
      default: begin
        // unused codes: nothing moves, plain done
      end
    endcase
    res.len = OUT_CNT_W'(left_cnt + right_cnt);
    res.cur = OUT_CNT_W'(left_cnt);
    edit_replies_q = {edit_replies_q, res};
  endfunction

  function automatic edit_req_t mk_edit(input logic [ACT_W-1:0] a,
                                        input logic [CHAR_W-1:0] c,
                                        input logic [POS_W-1:0] p);
    edit_req_t r;
    r.act = a;
    r.ch  = c;
    r.pos = p;
    return r;
  endfunction

  // queue a request and track the length and cursor it leaves behind
  function automatic void queue_edit(input edit_req_t r);
    case (r.act)
      ACT_INSERT: if (gen_len < CAPACITY) begin
        gen_len++;
        gen_cur++;
      end
      ACT_LEFT:  if (gen_cur > 0) gen_cur--;
      ACT_RIGHT: if (gen_cur < gen_len) gen_cur++;
      ACT_BKSP:  if (gen_cur > 0) begin
        gen_cur--;
        gen_len--;
      end
      default: ;
    endcase
    pending_edits_q = {pending_edits_q, r};
  endfunction

  // random request; ignored fields get random bits too
  function automatic edit_req_t make_random_edit(input traffic_e mode);
    edit_req_t   r;
    int unsigned roll;
    int unsigned w_ins;
    int unsigned w_left;
    int unsigned w_right;
    int unsigned w_bksp;
    int unsigned w_read;
    case (mode)
      FILL_UP: begin
        w_ins = 96; w_left = 1; w_right = 1; w_bksp = 1; w_read = 1;
      end
      MIX_FULL: begin
        w_ins = 25; w_left = 17; w_right = 17; w_bksp = 18; w_read = 18;
      end
      default: begin
        w_ins = 28; w_left = 17; w_right = 17; w_bksp = 18; w_read = 15;
      end
    endcase
    r.ch  = CHAR_W'($urandom_range((1 << CHAR_W) - 1));
    r.pos = POS_W'($urandom_range((1 << POS_W) - 1));
    roll  = $urandom_range(99);
    if (roll < w_ins) begin
      r.act = ACT_INSERT;
    end else if (roll < w_ins + w_left) begin
      r.act = ACT_LEFT;
    end else if (roll < w_ins + w_left + w_right) begin
      r.act = ACT_RIGHT;
    end else if (roll < w_ins + w_left + w_right + w_bksp) begin
      r.act = ACT_BKSP;
    end else if (roll < w_ins + w_left + w_right + w_bksp + w_read) begin
      r.act = ACT_READ;
      // mostly inside the text, the rest anywhere in the position range
      if (gen_len > 0 && $urandom_range(99) < 75) begin
        r.pos = POS_W'($urandom_range(gen_len - 1));
      end
    end else begin
      // codes above read carry no action
      r.act = ACT_W'($urandom_range((1 << ACT_W) - 1, ACT_READ + 1));
    end
    return r;
  endfunction

  // let queued traffic go out, then switch idle rates at a quiet point
  task automatic start_phase(input int unsigned src_pct, input int unsigned sink_pct);
    while (pending_edits_q.size() != 0) @(negedge clk_i);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
  endtask

  // request driver: launch from the queue whenever the channel is free
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      // request taken at this edge: predict its result now
      if (in_valid_i && in_ready_o) begin
        apply_edit(held_edit);
      end
      // channel free after this edge: next request, or an idle cycle
      if (!in_valid_i || in_ready_o) begin
        if (pending_edits_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          held_edit = pending_edits_q.pop_front();
          in_valid_i <= 1'b1;
          action_i   <= held_edit.act;
          char_in_i  <= held_edit.ch;
          position_i <= held_edit.pos;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor: random backpressure, compare each taken result in order
  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
      if (out_valid_o && out_ready_i) begin
        if (edit_replies_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS) begin
            $display({"result with no request outstanding: ",
                      "char %h len %0d cursor %0d status %0d"},
                     char_out_o, text_length_o, cursor_pos_o, status_o);
          end
        end else begin
          want_reply = edit_replies_q.pop_front();
          if (char_out_o !== want_reply.ch || text_length_o !== want_reply.len ||
              cursor_pos_o !== want_reply.cur || status_o !== want_reply.status) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS) begin
              $display({"result mismatch (exp/got): char %h/%h len %0d/%0d ",
                        "cursor %0d/%0d status %0d/%0d"},
                       want_reply.ch, char_out_o, want_reply.len, text_length_o,
                       want_reply.cur, cursor_pos_o, want_reply.status, status_o);
            end
          end
        end
      end
    end
  end

  // stimulus
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, no idling: ends of the cursor range on empty text, unused codes,
    // extreme characters, reads on both sides of the gap, mid-text insert and delete
    queue_edit(mk_edit(ACT_LEFT,   8'h00, '0));
    queue_edit(mk_edit(ACT_RIGHT,  8'h00, '0));
    queue_edit(mk_edit(ACT_BKSP,   8'h00, '0));
    queue_edit(mk_edit(ACT_READ,   8'h00, '0));
    queue_edit(mk_edit(ACT_READ,   8'h00, '1));
    queue_edit(mk_edit(ACT_W'(ACT_READ + 1), 8'hFF, '1));
    queue_edit(mk_edit(ACT_W'(ACT_READ + 2), 8'h00, '0));
    queue_edit(mk_edit(ACT_W'((1 << ACT_W) - 1), 8'hFF, '1));
    queue_edit(mk_edit(ACT_INSERT, 8'h00, '0));
    queue_edit(mk_edit(ACT_INSERT, 8'hFF, '1));
    queue_edit(mk_edit(ACT_INSERT, 8'hA5, '0));
    queue_edit(mk_edit(ACT_INSERT, 8'h5A, '0));
    queue_edit(mk_edit(ACT_RIGHT,  8'h00, '0));   // cursor already at end
    queue_edit(mk_edit(ACT_READ,   8'h00, 10'd0));
    queue_edit(mk_edit(ACT_READ,   8'h00, 10'd3));
    queue_edit(mk_edit(ACT_LEFT,   8'h00, '0));
    queue_edit(mk_edit(ACT_LEFT,   8'h00, '0));
    queue_edit(mk_edit(ACT_READ,   8'h00, 10'd1)); // left of the gap
    queue_edit(mk_edit(ACT_READ,   8'h00, 10'd2)); // first char right of the gap
    queue_edit(mk_edit(ACT_READ,   8'h00, 10'd3));
    queue_edit(mk_edit(ACT_INSERT, 8'h3C, '0));   // insert in the middle
    queue_edit(mk_edit(ACT_READ,   8'h00, 10'd4));
    queue_edit(mk_edit(ACT_READ,   8'h00, 10'd5)); // one past the end
    queue_edit(mk_edit(ACT_RIGHT,  8'h00, '0));
    queue_edit(mk_edit(ACT_BKSP,   8'h00, '0));   // delete in the middle

    // short text under each kind of idling
    start_phase(78, 0);
    repeat (25) queue_edit(make_random_edit(MIX_SHORT));
    start_phase(0, 78);
    repeat (25) queue_edit(make_random_edit(MIX_SHORT));
    start_phase(22, 22);
    repeat (25) queue_edit(make_random_edit(MIX_SHORT));

    // back to back: fill to capacity, knock on the full buffer, then edit near full
    start_phase(0, 0);
    while (gen_len < CAPACITY) queue_edit(make_random_edit(FILL_UP));
    repeat (12) queue_edit(make_random_edit(FILL_UP));
    repeat (20) queue_edit(make_random_edit(MIX_FULL));

    // near full with both sides idling
    start_phase(22, 22);
    repeat (30) queue_edit(make_random_edit(MIX_FULL));

    // all sent, all results back, then a short quiet tail for stray results
    while (pending_edits_q.size() != 0 || in_valid_i || edit_replies_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_cnt == 0 && edit_replies_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog for a hung handshake
  initial begin
    #(WATCHDOG_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule
